// File: design/channel_range_shift_remapper_top_defines.svh
// assertion macros for the channel range shift remapper
// used by the port checker; no other dependencies
`ifndef CHANNEL_RANGE_SHIFT_REMAPPER_TOP_DEFINES_SVH
`define CHANNEL_RANGE_SHIFT_REMAPPER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CRSR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crsr port check failed");

// next-cycle implication, disabled in reset
`define CRSR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crsr port check failed");

`endif

// File: design/crsr_pkg.sv
// shared constants, status codes and types of the channel range shift remapper
// no dependencies
package crsr_pkg;

    localparam int MAX_CONNECTORS = 64;
    localparam int CHANNEL_BITS   = 13;
    localparam int GAP_BITS       = 10;
    localparam int SHIFT_BITS     = CHANNEL_BITS + 1;
    localparam int MOVED_BITS     = CHANNEL_BITS + 2;
    localparam int STATUS_BITS    = 3;
    localparam int IDX_BITS       = (MAX_CONNECTORS > 1) ? $clog2(MAX_CONNECTORS) : 1;
    localparam int POS_BITS       = $clog2(MAX_CONNECTORS + 1);

    localparam logic [STATUS_BITS-1:0] ST_UNCHANGED = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_SHIFTED   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_MASKED    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_ADDED     = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_INVALID   = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_OVERLAP   = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd6;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef logic [CHANNEL_BITS-1:0]      chan_t;
    typedef logic [GAP_BITS-1:0]          gap_t;
    typedef logic signed [SHIFT_BITS-1:0] shift_t;
    typedef logic [STATUS_BITS-1:0]       status_t;

    // one stored connector range
    typedef struct packed {
        gap_t   gap;
        chan_t  first_ch;
        chan_t  last_ch;
        shift_t shift;
    } crsr_entry_t;

    // item travelling down the cell chain with what it has gathered so far
    typedef struct packed {
        logic                req_type;
        gap_t                gap;
        chan_t               channel;
        chan_t               first_ch;
        chan_t               last_ch;
        shift_t              shift;
        logic                invalid;
        logic                found;
        status_t             res_status;
        chan_t               res_channel;
        logic                overlap;
        logic                free_found;
        logic [IDX_BITS-1:0] free_idx;
        logic [POS_BITS-1:0] pos;
    } crsr_tok_t;

endpackage

// File: design/crsr_cell.sv
// one cell of the range chain: holds a connector range, checks the passing item
// depends on crsr_pkg
module crsr_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  crsr_pkg::crsr_tok_t  in_tok,
    output logic                 out_valid,
    output crsr_pkg::crsr_tok_t  out_tok,
    input  logic                 wr_sel,
    input  crsr_pkg::crsr_entry_t wr_entry
);
    import crsr_pkg::*;

    logic                   valid_reg;
    crsr_entry_t            entry_reg;
    logic                   vld_reg;
    crsr_tok_t              tok_reg;
    crsr_tok_t              tok_next;
    logic                   gap_hit;
    logic                   hit_ch;
    logic                   hit_first;
    logic                   hit_last;
    logic signed [MOVED_BITS-1:0] moved;
    logic signed [MOVED_BITS-1:0] lo_bound;
    logic signed [MOVED_BITS-1:0] hi_bound;

    assign gap_hit   = valid_reg && (entry_reg.gap == in_tok.gap);
    assign hit_ch    = gap_hit && (in_tok.channel >= entry_reg.first_ch)
                       && (in_tok.channel <= entry_reg.last_ch);
    assign hit_first = gap_hit && (in_tok.first_ch >= entry_reg.first_ch)
                       && (in_tok.first_ch <= entry_reg.last_ch);
    assign hit_last  = gap_hit && (in_tok.last_ch >= entry_reg.first_ch)
                       && (in_tok.last_ch <= entry_reg.last_ch);

    assign moved    = signed'({2'b00, in_tok.channel}) + MOVED_BITS'(entry_reg.shift);
    assign lo_bound = signed'({2'b00, entry_reg.first_ch});
    assign hi_bound = signed'({2'b00, entry_reg.last_ch});

    always_comb
    begin
        tok_next     = in_tok;
        tok_next.pos = in_tok.pos + POS_BITS'(1);
        if (in_tok.req_type == REQ_LOOKUP)
        begin
            // lowest matching cell wins
            if (!in_tok.found && hit_ch)
            begin
                tok_next.found = 1'b1;
                if (moved < lo_bound || moved > hi_bound)
                begin
                    tok_next.res_status  = ST_MASKED;
                    tok_next.res_channel = '0;
                end
                else
                begin
                    tok_next.res_status  = ST_SHIFTED;
                    tok_next.res_channel = moved[CHANNEL_BITS-1:0];
                end
            end
        end
        else
        begin
            if (hit_first || hit_last)
                tok_next.overlap = 1'b1;
            if (!valid_reg && !in_tok.free_found)
            begin
                tok_next.free_found = 1'b1;
                tok_next.free_idx   = in_tok.pos[IDX_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            vld_reg <= in_valid;
            if (wr_sel)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (wr_sel)
            entry_reg <= wr_entry;
    end

    assign out_valid = vld_reg;
    assign out_tok   = tok_reg;

endmodule

// File: design/channel_range_shift_remapper_top.sv
// top level of the channel range shift remapper: input stage, cell chain, result stage
// depends on crsr_pkg and crsr_cell
//
// usage
//  - one command channel: an item is taken at a rising edge with start high and
//    busy low; req_type selects an add of a connector range or a channel lookup
//  - one result per item on status / out_channel, marked by done for exactly
//    one cycle; the receiver cannot hold it off
//  - the item is registered at the input, then walks down a row of
//    MAX_CONNECTORS cells, one cell per cycle; each cell holds one range and
//    compares it against the passing item
//  - result: the item passes the input register and every cell in turn, and done
//    is registered from the last cell's output; busy drops together with done rising
//  - a new item is taken only once busy has dropped, so only one item at a time
//    walks through the whole chain
//  - an accepted add writes the lowest free cell at the edge that raises done,
//    so the next item already sees it
//  - reset clears all cell valid bits, busy and done; the table starts empty
//
module channel_range_shift_remapper_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic [crsr_pkg::GAP_BITS-1:0]        gap_key,
    input  logic [crsr_pkg::CHANNEL_BITS-1:0]    channel,
    input  logic [crsr_pkg::CHANNEL_BITS-1:0]    first_channel,
    input  logic [crsr_pkg::CHANNEL_BITS-1:0]    last_channel,
    input  logic signed [crsr_pkg::SHIFT_BITS-1:0] shift_amount,
    output logic                                 done,
    output logic [crsr_pkg::STATUS_BITS-1:0]     status,
    output logic [crsr_pkg::CHANNEL_BITS-1:0]    out_channel
);
    import crsr_pkg::*;

    // chain hand-off: stage 0 is the input register, stage i+1 leaves cell i
    logic        stage_vld [0:MAX_CONNECTORS];
    crsr_tok_t   stage_tok [0:MAX_CONNECTORS];

    logic        in_vld_reg;
    crsr_tok_t   in_tok_reg;
    crsr_tok_t   in_tok_next;
    logic        busy_reg;
    logic        done_reg;
    status_t     status_reg;
    status_t     status_next;
    chan_t       out_channel_reg;
    chan_t       out_channel_next;
    logic        wr_en;
    crsr_entry_t wr_entry;
    crsr_tok_t   last_tok;
    logic        accept;

    assign accept = start && !busy_reg;

    // build the item as it enters the chain; invalid adds are flagged up front
    always_comb
    begin
        in_tok_next             = '0;
        in_tok_next.req_type    = req_type;
        in_tok_next.gap         = gap_key;
        in_tok_next.channel     = channel;
        in_tok_next.first_ch    = first_channel;
        in_tok_next.last_ch     = last_channel;
        in_tok_next.shift       = shift_amount;
        in_tok_next.invalid     = (first_channel >= last_channel) || (shift_amount == '0);
        // a lookup that finds no range passes the channel through
        in_tok_next.res_status  = ST_UNCHANGED;
        in_tok_next.res_channel = channel;
    end

    assign stage_vld[0] = in_vld_reg;
    assign stage_tok[0] = in_tok_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CONNECTORS; gi++)
        begin : g_cell
            logic wr_sel;
            assign wr_sel = wr_en && (last_tok.free_idx == IDX_BITS'(gi));

            crsr_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stage_vld[gi]),
                .in_tok    (stage_tok[gi]),
                .out_valid (stage_vld[gi+1]),
                .out_tok   (stage_tok[gi+1]),
                .wr_sel    (wr_sel),
                .wr_entry  (wr_entry)
            );
        end
    endgenerate

    assign last_tok = stage_tok[MAX_CONNECTORS];

    // final decision: a lookup takes the chain's result; an add checks invalid first, then overlap, then table full
    always_comb
    begin
        wr_en            = 1'b0;
        status_next      = ST_FULL;
        out_channel_next = '0;
        if (last_tok.req_type == REQ_LOOKUP)
        begin
            status_next      = last_tok.res_status;
            out_channel_next = last_tok.res_channel;
        end
        else if (last_tok.invalid)
            status_next = ST_INVALID;
        else if (last_tok.overlap)
            status_next = ST_OVERLAP;
        else if (last_tok.free_found)
        begin
            status_next = ST_ADDED;
            wr_en       = stage_vld[MAX_CONNECTORS];
        end
    end

    assign wr_entry.gap      = last_tok.gap;
    assign wr_entry.first_ch = last_tok.first_ch;
    assign wr_entry.last_ch  = last_tok.last_ch;
    assign wr_entry.shift    = last_tok.shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
            done_reg   <= stage_vld[MAX_CONNECTORS];
            if (accept)
                busy_reg <= 1'b1;
            else if (stage_vld[MAX_CONNECTORS])
                busy_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            in_tok_reg <= in_tok_next;
        if (stage_vld[MAX_CONNECTORS])
        begin
            status_reg      <= status_next;
            out_channel_reg <= out_channel_next;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign out_channel = out_channel_reg;

endmodule

// File: design/crsr_checker.sv
// port-level checker for the channel range shift remapper, bound to the top level
// depends on crsr_pkg and channel_range_shift_remapper_top_defines.svh
`include "channel_range_shift_remapper_top_defines.svh"

module crsr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [crsr_pkg::STATUS_BITS-1:0]  status,
    input logic [crsr_pkg::CHANNEL_BITS-1:0] out_channel
);
    import crsr_pkg::*;

    // an accepted item keeps the block busy
    `CRSR_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // busy only ends with a result
    `CRSR_ASSERT_IMP(a_busy_end_done, clk, rst_n, $fell(busy), done)
    // one strobe per item
    `CRSR_ASSERT_NXT(a_single_done, clk, rst_n, done, !done)
    // only pass-through and shifted results carry a channel
    `CRSR_ASSERT_IMP(a_zero_channel, clk, rst_n,
        done && status != ST_UNCHANGED && status != ST_SHIFTED, out_channel == '0)
    // status code in its range
    `CRSR_ASSERT_IMP(a_status_range, clk, rst_n, done, status <= ST_FULL)

endmodule

bind channel_range_shift_remapper_top crsr_checker u_crsr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .out_channel (out_channel)
);

// File: tb/sv/channel_range_shift_remapper_top_tb.sv
// self-checking testbench for channel_range_shift_remapper_top: directed and random
// add / lookup items, checked against an in-bench model of the range table
// depends on crsr_pkg and the remapper rtl
module channel_range_shift_remapper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crsr_pkg::*;

    // one queued command item plus the idle cycles the sender inserts before it
    typedef struct {
        logic   req;
        gap_t   gap;
        chan_t  ch;
        chan_t  first_ch;
        chan_t  last_ch;
        shift_t shift;
        int     idle_before;
    } request_t;

    // one expected result
    typedef struct {
        status_t status;
        chan_t   chan;
    } remap_result_t;

    // a range handed to the block by the stimulus, used to aim later items at it
    typedef struct {
        gap_t  gap;
        chan_t lo;
        chan_t hi;
    } span_t;

    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   CHAN_MAX       = (1 << CHANNEL_BITS) - 1;
    localparam gap_t GAP_MAX        = '1;

    logic   clk           = 1'b0;
    logic   rst_n         = 1'b0;
    logic   start         = 1'b0;
    logic   req_type      = REQ_LOOKUP;
    gap_t   gap_key       = '0;
    chan_t  channel       = '0;
    chan_t  first_channel = '0;
    chan_t  last_channel  = '0;
    shift_t shift_amount  = '0;
    logic    busy;
    logic    done;
    status_t status;
    chan_t   out_channel;

    request_t      pending_requests[$];
    remap_result_t expected_results[$];
    span_t         known_ranges[$];

    // shadow copy of the connector table
    bit     range_used [MAX_CONNECTORS];
    gap_t   range_gap  [MAX_CONNECTORS];
    chan_t  range_lo   [MAX_CONNECTORS];
    chan_t  range_hi   [MAX_CONNECTORS];
    shift_t range_shift[MAX_CONNECTORS];

    int launched_count = 0;
    int taken_count    = 0;
    int error_count    = 0;
    int add_count      = 0;
    int lookup_count   = 0;
    int stall_cycles   = 0;
    int idle_left      = -1;
    int idle_max       = 8;
    int status_seen[8];

    channel_range_shift_remapper_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .gap_key      (gap_key),
        .channel      (channel),
        .first_channel(first_channel),
        .last_channel (last_channel),
        .shift_amount (shift_amount),
        .done         (done),
        .status       (status),
        .out_channel  (out_channel)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic chan_t clip_chan(int v);
        if (v < 0)
            return '0;
        if (v > CHAN_MAX)
            return chan_t'(CHAN_MAX);
        return chan_t'(v);
    endfunction

    // lowest used cell of the gap whose inclusive range holds ch, or -1
    function automatic int find_range(gap_t gap, chan_t ch);
        for (int i = 0; i < MAX_CONNECTORS; i++)
        begin
            if (range_used[i] && range_gap[i] == gap && ch >= range_lo[i] && ch <= range_hi[i])
                return i;
        end
        return -1;
    endfunction

    // result of one item; an accepted add goes into the shadow table
    function automatic remap_result_t remap_request(request_t rq);
        remap_result_t res;
        int hit;
        int slot;
        int moved;
        res.status = ST_UNCHANGED;
        res.chan   = '0;
        slot       = -1;
        if (rq.req == REQ_LOOKUP)
        begin
            hit = find_range(rq.gap, rq.ch);
            if (hit < 0)
            begin
                res.chan = rq.ch;
            end
            else
            begin
                moved = int'(rq.ch) + int'(range_shift[hit]);
                if (moved < int'(range_lo[hit]) || moved > int'(range_hi[hit]))
                    res.status = ST_MASKED;
                else
                begin
                    res.status = ST_SHIFTED;
                    res.chan   = chan_t'(moved);
                end
            end
        end
        else if (rq.first_ch >= rq.last_ch || rq.shift == 0)
            res.status = ST_INVALID;
        else if (find_range(rq.gap, rq.first_ch) >= 0 || find_range(rq.gap, rq.last_ch) >= 0)
            res.status = ST_OVERLAP;
        else
        begin
            for (int i = MAX_CONNECTORS - 1; i >= 0; i--)
            begin
                if (!range_used[i])
                    slot = i;
            end
            if (slot < 0)
                res.status = ST_FULL;
            else
            begin
                range_used[slot]  = 1'b1;
                range_gap[slot]   = rq.gap;
                range_lo[slot]    = rq.first_ch;
                range_hi[slot]    = rq.last_ch;
                range_shift[slot] = rq.shift;
                res.status        = ST_ADDED;
            end
        end
        return res;
    endfunction

    // queue an add; the unused channel field carries noise
    function automatic void queue_add(gap_t gap, int lo, int hi, int shift);
        request_t rq;
        span_t    sp;
        rq.req         = REQ_ADD;
        rq.gap         = gap;
        rq.ch          = chan_t'($urandom_range(0, CHAN_MAX));
        rq.first_ch    = clip_chan(lo);
        rq.last_ch     = clip_chan(hi);
        rq.shift       = shift_t'(shift);
        rq.idle_before = $urandom_range(0, idle_max);
        pending_requests.push_back(rq);
        if (rq.first_ch < rq.last_ch)
        begin
            sp.gap = gap;
            sp.lo  = rq.first_ch;
            sp.hi  = rq.last_ch;
            known_ranges.push_back(sp);
        end
    endfunction

    // queue a lookup; the unused range fields carry noise
    function automatic void queue_lookup(gap_t gap, int ch);
        request_t rq;
        rq.req         = REQ_LOOKUP;
        rq.gap         = gap;
        rq.ch          = clip_chan(ch);
        rq.first_ch    = chan_t'($urandom_range(0, CHAN_MAX));
        rq.last_ch     = chan_t'($urandom_range(0, CHAN_MAX));
        rq.shift       = shift_t'(int'($urandom_range(0, 2 * CHAN_MAX)) - CHAN_MAX);
        rq.idle_before = $urandom_range(0, idle_max);
        pending_requests.push_back(rq);
    endfunction

    // driver: inputs move on the falling edge only
    // - the item on the pins stays put until the monitor has seen it taken
    // - idle cycles of an item are counted only once the block is free again,
    //   except a count of zero, which puts start up while busy is still high
    always @(negedge clk)
    begin
        if (rst_n && (!start || taken_count == launched_count))
        begin
            if (pending_requests.size() == 0)
                start <= 1'b0;
            else
            begin
                if (idle_left < 0)
                    idle_left = pending_requests[0].idle_before;
                if (idle_left > 0)
                begin
                    if (!busy)
                        idle_left--;
                    start <= 1'b0;
                end
                else
                begin
                    req_type      <= pending_requests[0].req;
                    gap_key       <= pending_requests[0].gap;
                    channel       <= pending_requests[0].ch;
                    first_channel <= pending_requests[0].first_ch;
                    last_channel  <= pending_requests[0].last_ch;
                    shift_amount  <= pending_requests[0].shift;
                    start         <= 1'b1;
                    void'(pending_requests.pop_front());
                    idle_left = -1;
                    launched_count++;
                end
            end
        end
    end

    // monitor: samples on the rising edge
    // - a done strobe is checked against the oldest expectation
    // - an item taken at this edge is predicted right away, so the shadow
    //   table follows the order in which the block takes items
    // - the watchdog counts edges at which nothing moves
    always @(posedge clk)
    begin
        request_t      rq;
        remap_result_t want;
        bit            moved_any;
        if (rst_n)
        begin
            moved_any = 1'b0;
            if (done)
            begin
                moved_any = 1'b1;
                status_seen[status]++;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d out_channel %0d",
                           status, out_channel);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (out_channel !== want.chan)
                    begin
                        $error("out_channel mismatch: expected %0d, got %0d",
                               want.chan, out_channel);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                moved_any   = 1'b1;
                rq.req      = req_type;
                rq.gap      = gap_key;
                rq.ch       = channel;
                rq.first_ch = first_channel;
                rq.last_ch  = last_channel;
                rq.shift    = shift_amount;
                expected_results.push_back(remap_request(rq));
                if (req_type == REQ_ADD)
                    add_count++;
                else
                    lookup_count++;
                taken_count++;
            end
            stall_cycles = moved_any ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        gap_t  gap_pool[6];
        span_t r;
        gap_t  g;
        int    kind;
        int    lo;
        int    hi;
        int    span;
        int    mag;
        int    shift;
        int    c;

        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (range_used[i])
            range_used[i] = 1'b0;

        // directed part, table empty at first
        queue_lookup(0, 0);                     // miss at the low corners
        queue_lookup(GAP_MAX, CHAN_MAX);        // miss at the high corners
        queue_add(5, 10, 10, 1);                // single channel range
        queue_add(5, 20, 10, 1);                // reversed range
        queue_add(5, 10, 20, 0);                // zero shift
        queue_add(5, 100, 200, 5);              // first range of gap 5
        queue_add(5, 150, 300, 1);              // first endpoint inside
        queue_add(5, 50, 100, 1);               // last endpoint on a bound
        queue_add(5, 150, 160, 0);              // invalid wins over overlap
        queue_add(5, 50, 400, -3);              // encloses the first range
        queue_add(6, 100, 200, 5);              // same range, other gap
        queue_lookup(5, 100);                   // inner range wins, shifted
        queue_lookup(5, 200);                   // shifted past the last channel
        queue_lookup(5, 60);                    // outer range, shifted down
        queue_lookup(5, 51);                    // shifted below the first channel
        queue_lookup(5, 401);                   // just outside every range
        queue_lookup(7, 150);                   // gap with no ranges
        queue_add(0, 0, CHAN_MAX, CHAN_MAX);    // widest range, largest shift
        queue_lookup(0, 0);
        queue_lookup(0, 1);
        queue_add(GAP_MAX, 0, CHAN_MAX, -CHAN_MAX);
        queue_lookup(GAP_MAX, CHAN_MAX);
        queue_lookup(GAP_MAX, CHAN_MAX - 1);
        queue_lookup(6, 195);
        queue_lookup(6, 100);

        // random part: a few hot gaps so ranges collide, nest and fill the table
        gap_pool[0] = 0;
        gap_pool[1] = GAP_MAX;
        gap_pool[2] = 5;
        gap_pool[3] = 6;
        gap_pool[4] = gap_t'($urandom_range(0, GAP_MAX));
        gap_pool[5] = gap_t'($urandom_range(0, GAP_MAX));
        for (int n = 0; n < 1250; n++)
        begin
            // every fourth stretch of 125 items runs without sender gaps
            idle_max = ((n / 125) % 4 == 1) ? 0 : 8;
            g = ($urandom_range(0, 9) == 0) ? gap_t'($urandom_range(0, GAP_MAX))
                                            : gap_pool[$urandom_range(0, 5)];
            if ($urandom_range(0, 4) == 0)
            begin
                kind = $urandom_range(0, 9);
                lo   = $urandom_range(0, CHAN_MAX);
                hi   = lo + (($urandom_range(0, 9) < 7) ? $urandom_range(1, 64)
                                                         : $urandom_range(1, CHAN_MAX));
                if (kind == 0)
                    hi = $urandom_range(0, lo);     // empty or reversed
                else if (kind >= 2 && kind <= 4 && known_ranges.size() != 0)
                begin
                    r = known_ranges[$urandom_range(0, known_ranges.size() - 1)];
                    g = r.gap;
                    if (kind == 2)
                    begin
                        lo = $urandom_range(r.lo, r.hi);
                        hi = lo + $urandom_range(1, 64);
                    end
                    else if (kind == 3)
                    begin
                        hi = $urandom_range(r.lo, r.hi);
                        lo = hi - int'($urandom_range(1, 64));
                    end
                    else
                    begin
                        lo = int'(r.lo) - int'($urandom_range(1, 40));
                        hi = int'(r.hi) + int'($urandom_range(1, 40));
                    end
                end
                span = int'(clip_chan(hi)) - int'(clip_chan(lo));
                if (span < 1)
                    span = 1;
                // mostly shifts that stay inside the range, some far outside
                mag   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, span)
                                                   : $urandom_range(1, CHAN_MAX);
                shift = $urandom_range(0, 1) ? mag : -mag;
                if (kind == 1)
                    shift = 0;
                queue_add(g, lo, hi, shift);
            end
            else if (known_ranges.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                // aim at a known range, its bounds and just past them
                r = known_ranges[$urandom_range(0, known_ranges.size() - 1)];
                case ($urandom_range(0, 3))
                    0: c = int'(r.lo);
                    1: c = int'(r.hi);
                    default:
                    begin
                        c = $urandom_range(r.lo, r.hi);
                        c = c + int'($urandom_range(0, 4)) - 2;
                    end
                endcase
                queue_lookup(r.gap, c);
            end
            else
                queue_lookup(g, $urandom_range(0, CHAN_MAX));
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: every item taken and every result back, then a wait past the length of the chain
        while (pending_requests.size() != 0 || taken_count != launched_count ||
               expected_results.size() != 0)
            @(negedge clk);
        repeat (MAX_CONNECTORS + 8) @(negedge clk);

        $display("run covered %0d items: %0d adds, %0d lookups",
                 taken_count, add_count, lookup_count);
        $display("statuses: unch %0d shft %0d mask %0d add %0d inv %0d ovl %0d full %0d",
                 status_seen[ST_UNCHANGED], status_seen[ST_SHIFTED], status_seen[ST_MASKED],
                 status_seen[ST_ADDED], status_seen[ST_INVALID], status_seen[ST_OVERLAP],
                 status_seen[ST_FULL]);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/crsr_pkg.sv
design/crsr_cell.sv
design/channel_range_shift_remapper_top.sv
design/crsr_checker.sv
tb/sv/channel_range_shift_remapper_top_tb.sv
